// ===== design/dpqmm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpqmm_pkg - shared types and constants for the dual pid quad motor mixer
// field widths, register codes, reset values and pipeline structs
// ----------------------------------------------------------------------------
package dpqmm_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int ANG_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 17;
  localparam int SUM_W      = 18;
  localparam int DIFF_W     = 18;
  localparam int PROD_W     = 35;
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int PID_W      = TERM_W + 2;
  localparam int MIX_W      = PID_W + 2;
  localparam int MOT_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  localparam logic [MOT_W-1:0] FULL_SCALE = 15'd25600;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_KP  = 3'd0,
    REG_PITCH_KI  = 3'd1,
    REG_PITCH_KD  = 3'd2,
    REG_ROLL_KP   = 3'd3,
    REG_ROLL_KI   = 3'd4,
    REG_ROLL_KD   = 3'd5,
    REG_INT_LIMIT = 3'd6
  } cfg_idx_t;

  localparam logic [GAIN_W-1:0] KP_RST    = 16'd512;
  localparam logic [GAIN_W-1:0] KI_RST    = 16'd128;
  localparam logic [GAIN_W-1:0] KD_RST    = 16'd26;
  localparam logic [GAIN_W-1:0] LIMIT_RST = 16'd51200;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } axis_gain_t;

  typedef struct packed {
    axis_gain_t        pitch;
    axis_gain_t        roll;
    logic [GAIN_W-1:0] int_limit;
  } cfg_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] meas_roll;
    logic signed [ANG_W-1:0] meas_pitch;
    logic signed [ANG_W-1:0] tgt_roll;
    logic signed [ANG_W-1:0] tgt_pitch;
    logic signed [ANG_W-1:0] throttle;
  } in_item_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
  } axis_err_t;

  typedef struct packed {
    logic [MOT_W-1:0] thr;
    axis_err_t        pitch;
    axis_err_t        roll;
  } err_item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] p;
    logic signed [TERM_W-1:0] i;
    logic signed [TERM_W-1:0] d;
  } axis_terms_t;

  typedef struct packed {
    logic [MOT_W-1:0] thr;
    axis_terms_t      pitch;
    axis_terms_t      roll;
  } term_item_t;

  typedef struct packed {
    logic [MOT_W-1:0] front_left;
    logic [MOT_W-1:0] front_right;
    logic [MOT_W-1:0] back_left;
    logic [MOT_W-1:0] back_right;
  } motor_item_t;

endpackage

// ===== design/dpqmm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dpqmm_cfg_regs - gain and limit registers
// write-only register file, writes to unused indexes are dropped
// ----------------------------------------------------------------------------
module dpqmm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dpqmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpqmm_pkg::GAIN_W-1:0]   cfg_wdata,
  output dpqmm_pkg::cfg_t                cfg
);
  import dpqmm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_PITCH_KP:  cfg_nxt.pitch.kp  = cfg_wdata;
        REG_PITCH_KI:  cfg_nxt.pitch.ki  = cfg_wdata;
        REG_PITCH_KD:  cfg_nxt.pitch.kd  = cfg_wdata;
        REG_ROLL_KP:   cfg_nxt.roll.kp   = cfg_wdata;
        REG_ROLL_KI:   cfg_nxt.roll.ki   = cfg_wdata;
        REG_ROLL_KD:   cfg_nxt.roll.kd   = cfg_wdata;
        REG_INT_LIMIT: cfg_nxt.int_limit = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pitch.kp  <= KP_RST;
      cfg_r.pitch.ki  <= KI_RST;
      cfg_r.pitch.kd  <= KD_RST;
      cfg_r.roll.kp   <= KP_RST;
      cfg_r.roll.ki   <= KI_RST;
      cfg_r.roll.kd   <= KD_RST;
      cfg_r.int_limit <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/dpqmm_err_stage.sv =====
// ----------------------------------------------------------------------------
// dpqmm_err_stage - error, clamped integral and derivative per axis
// holds the integral and previous-error state, clamps the throttle
// ----------------------------------------------------------------------------
module dpqmm_err_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dpqmm_pkg::pipe_ctl_t          ctl,
  input  dpqmm_pkg::in_item_t           in_item,
  input  logic [dpqmm_pkg::GAIN_W-1:0]  int_limit,
  output dpqmm_pkg::err_item_t          err_item
);
  import dpqmm_pkg::*;

  logic signed [SUM_W-1:0] pitch_sum_r, roll_sum_r;
  logic signed [ERR_W-1:0] pitch_prev_r, roll_prev_r;
  err_item_t               err_item_r, err_item_nxt;

  function automatic axis_err_t axis_update(
    input logic signed [ANG_W-1:0] tgt,
    input logic signed [ANG_W-1:0] meas,
    input logic signed [SUM_W-1:0] sum,
    input logic signed [ERR_W-1:0] prev,
    input logic [GAIN_W-1:0]       lim
  );
    logic signed [ERR_W-1:0]  e;
    logic signed [SUM_W:0]    full;
    logic signed [SUM_W:0]    hi;
    logic signed [SUM_W:0]    lo;
    axis_err_t                r;
    e    = $signed({tgt[ANG_W-1], tgt}) - $signed({meas[ANG_W-1], meas});
    full = $signed({sum[SUM_W-1], sum}) + $signed({{2{e[ERR_W-1]}}, e});
    hi   = $signed({3'b000, lim});
    lo   = -hi;
    r.err = e;
    if (full > hi)      r.sum = hi[SUM_W-1:0];
    else if (full < lo) r.sum = lo[SUM_W-1:0];
    else                r.sum = full[SUM_W-1:0];
    r.diff = $signed({e[ERR_W-1], e}) - $signed({prev[ERR_W-1], prev});
    return r;
  endfunction

  always_comb begin
    err_item_nxt.pitch = axis_update(in_item.tgt_pitch, in_item.meas_pitch,
                                     pitch_sum_r, pitch_prev_r, int_limit);
    err_item_nxt.roll  = axis_update(in_item.tgt_roll, in_item.meas_roll,
                                     roll_sum_r, roll_prev_r, int_limit);
    // throttle limited to 0..100 percent
    if (in_item.throttle[ANG_W-1])
      err_item_nxt.thr = '0;
    else if (in_item.throttle > $signed({1'b0, FULL_SCALE}))
      err_item_nxt.thr = FULL_SCALE;
    else
      err_item_nxt.thr = in_item.throttle[MOT_W-1:0];
  end

  // loop state moves only with a real transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_sum_r  <= '0;
      roll_sum_r   <= '0;
      pitch_prev_r <= '0;
      roll_prev_r  <= '0;
    end else if (ctl.adv && ctl.vld) begin
      pitch_sum_r  <= err_item_nxt.pitch.sum;
      roll_sum_r   <= err_item_nxt.roll.sum;
      pitch_prev_r <= err_item_nxt.pitch.err;
      roll_prev_r  <= err_item_nxt.roll.err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) err_item_r <= err_item_nxt;
  end

  assign err_item = err_item_r;

endmodule

// ===== design/dpqmm_gain_stage.sv =====
// ----------------------------------------------------------------------------
// dpqmm_gain_stage - gain products
// six gain times value products, each floored by the fraction width
// ----------------------------------------------------------------------------
module dpqmm_gain_stage (
  input  logic                  clk,
  input  dpqmm_pkg::pipe_ctl_t  ctl,
  input  dpqmm_pkg::cfg_t       cfg,
  input  dpqmm_pkg::err_item_t  err_item,
  output dpqmm_pkg::term_item_t term_item
);
  import dpqmm_pkg::*;

  term_item_t term_item_r, term_item_nxt;

  function automatic logic signed [TERM_W-1:0] mul_floor(
    input logic [GAIN_W-1:0]        g,
    input logic signed [SUM_W-1:0]  x
  );
    logic signed [PROD_W-1:0] p;
    // 17 by 18 signed product, exact in PROD_W bits
    p = $signed({1'b0, g}) * x;
    return p[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic axis_terms_t axis_terms(
    input axis_gain_t g,
    input axis_err_t  v
  );
    axis_terms_t t;
    t.p = mul_floor(g.kp, $signed({v.err[ERR_W-1], v.err}));
    t.i = mul_floor(g.ki, v.sum);
    t.d = mul_floor(g.kd, v.diff);
    return t;
  endfunction

  always_comb begin
    term_item_nxt.thr   = err_item.thr;
    term_item_nxt.pitch = axis_terms(cfg.pitch, err_item.pitch);
    term_item_nxt.roll  = axis_terms(cfg.roll, err_item.roll);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) term_item_r <= term_item_nxt;
  end

  assign term_item = term_item_r;

endmodule

// ===== design/dpqmm_mix_stage.sv =====
// ----------------------------------------------------------------------------
// dpqmm_mix_stage - pid sum and x-quad mixer
// adds the pid terms, mixes with throttle and clamps each motor
// ----------------------------------------------------------------------------
module dpqmm_mix_stage (
  input  logic                   clk,
  input  dpqmm_pkg::pipe_ctl_t   ctl,
  input  dpqmm_pkg::term_item_t  term_item,
  output dpqmm_pkg::motor_item_t motor_item
);
  import dpqmm_pkg::*;

  motor_item_t             motor_item_r, motor_item_nxt;
  logic signed [PID_W-1:0] pitch_pid, roll_pid;
  logic signed [MIX_W-1:0] thr_x, pitch_x, roll_x;

  function automatic logic signed [PID_W-1:0] pid_sum(input axis_terms_t t);
    return $signed({{2{t.p[TERM_W-1]}}, t.p}) +
           $signed({{2{t.i[TERM_W-1]}}, t.i}) +
           $signed({{2{t.d[TERM_W-1]}}, t.d});
  endfunction

  function automatic logic [MOT_W-1:0] clamp_motor(
    input logic signed [MIX_W-1:0] v
  );
    logic [MOT_W-1:0] r;
    if (v[MIX_W-1])
      r = '0;
    else if (v > $signed({{(MIX_W-MOT_W){1'b0}}, FULL_SCALE}))
      r = FULL_SCALE;
    else
      r = v[MOT_W-1:0];
    return r;
  endfunction

  always_comb begin
    pitch_pid = pid_sum(term_item.pitch);
    roll_pid  = pid_sum(term_item.roll);
    thr_x     = $signed({{(MIX_W-MOT_W){1'b0}}, term_item.thr});
    pitch_x   = $signed({{2{pitch_pid[PID_W-1]}}, pitch_pid});
    roll_x    = $signed({{2{roll_pid[PID_W-1]}}, roll_pid});
    motor_item_nxt.front_left  = clamp_motor(thr_x + pitch_x + roll_x);
    motor_item_nxt.front_right = clamp_motor(thr_x + pitch_x - roll_x);
    motor_item_nxt.back_left   = clamp_motor(thr_x - pitch_x + roll_x);
    motor_item_nxt.back_right  = clamp_motor(thr_x - pitch_x - roll_x);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) motor_item_r <= motor_item_nxt;
  end

  assign motor_item = motor_item_r;

endmodule

// ===== design/dual_pid_quad_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// dual_pid_quad_motor_mixer - roll/pitch pid attitude loop with x-quad mixer
// four-stage stream pipeline taking one attitude sample per transaction
// ----------------------------------------------------------------------------
// the block takes one attitude sample per cycle while the output is not stalled
// and returns one set of four motor commands per sample; the rate is set by the
// integral add-and-clamp loop in the error stage, which closes within that
// stage so samples may follow back to back. the whole pipeline moves
// together: in_tready is high whenever the output register is empty or being
// drained, so a stalled output holds every stage. all values are signed q8.8,
// gains unsigned q8.8; products are floored by 8 bits and the motor commands
// are clamped to 0..25600 (0..100 percent). the integrals and previous errors
// clear on reset; write gains and the integral limit only while no sample is
// in flight
module dual_pid_quad_motor_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_wr_en,
  input  logic [dpqmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpqmm_pkg::GAIN_W-1:0]        cfg_wdata,
  // attitude sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // lsb up: measured_roll_angle, measured_pitch_angle, target_roll_angle,
  //         target_pitch_angle, throttle_in (16 bits each)
  input  logic [dpqmm_pkg::IN_DATA_W-1:0]     in_tdata,
  // motor command stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // lsb up: motor_front_left, motor_front_right, motor_back_left,
  //         motor_back_right (15 bits each), 4 zero pad bits
  output logic [dpqmm_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import dpqmm_pkg::*;

  logic        adv;
  logic        in_vld_r, err_vld_r, term_vld_r, out_vld_r;
  in_item_t    in_item_r;
  cfg_t        cfg;
  err_item_t   err_item;
  term_item_t  term_item;
  motor_item_t motor_item;
  pipe_ctl_t   err_ctl, term_ctl, mix_ctl;

  // global advance: output free or being taken this cycle
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  assign err_ctl  = '{adv: adv, vld: in_vld_r};
  assign term_ctl = '{adv: adv, vld: err_vld_r};
  assign mix_ctl  = '{adv: adv, vld: term_vld_r};

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      err_vld_r  <= 1'b0;
      term_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (adv) begin
      in_vld_r   <= in_tvalid;
      err_vld_r  <= in_vld_r;
      term_vld_r <= err_vld_r;
      out_vld_r  <= term_vld_r;
    end
  end

  // input register, unpacking the transaction
  always_ff @(posedge clk) begin
    if (adv) begin
      in_item_r.meas_roll  <= $signed(in_tdata[15:0]);
      in_item_r.meas_pitch <= $signed(in_tdata[31:16]);
      in_item_r.tgt_roll   <= $signed(in_tdata[47:32]);
      in_item_r.tgt_pitch  <= $signed(in_tdata[63:48]);
      in_item_r.throttle   <= $signed(in_tdata[79:64]);
    end
  end

  dpqmm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // errors, integrals and derivatives; owns the loop state
  dpqmm_err_stage u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (err_ctl),
    .in_item   (in_item_r),
    .int_limit (cfg.int_limit),
    .err_item  (err_item)
  );

  // gain multipliers
  dpqmm_gain_stage u_gain (
    .clk       (clk),
    .ctl       (term_ctl),
    .cfg       (cfg),
    .err_item  (err_item),
    .term_item (term_item)
  );

  // pid sum, mix and clamp into the output register
  dpqmm_mix_stage u_mix (
    .clk        (clk),
    .ctl        (mix_ctl),
    .term_item  (term_item),
    .motor_item (motor_item)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, motor_item.back_right, motor_item.back_left,
                       motor_item.front_right, motor_item.front_left};

endmodule

// ===== design/dpqmm_checker.sv =====
// ----------------------------------------------------------------------------
// dpqmm_checker - port-level checks for the motor mixer
// output hold, command range, backpressure and reset behaviour
// ----------------------------------------------------------------------------
module dpqmm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic [dpqmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [dpqmm_pkg::GAIN_W-1:0]     cfg_wdata,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [dpqmm_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dpqmm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dpqmm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every motor command within full scale, pad bits zero
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:0] <= FULL_SCALE && out_tdata[29:15] <= FULL_SCALE &&
                   out_tdata[44:30] <= FULL_SCALE && out_tdata[59:45] <= FULL_SCALE &&
                   out_tdata[63:60] == 4'b0000)
    else $error("motor command out of range");

  // input side moves exactly when the output register can
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output state");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dual_pid_quad_motor_mixer dpqmm_checker u_dpqmm_checker (.*);

// ===== verif/dpqmm_mixer_checker.sv =====
// ----------------------------------------------------------------------------
// dpqmm_mixer_checker - motor command predictor and scoreboard
// mirrors the register writes and attitude samples seen on the block's ports,
// works out the four motor commands of each sample and compares them with
// the command transactions the block returns
// ----------------------------------------------------------------------------
module dpqmm_mixer_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [dpqmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpqmm_pkg::GAIN_W-1:0]     cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // lsb up: measured roll, measured pitch, target roll, target pitch, throttle
  input  logic [dpqmm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // lsb up: front left, front right, back left, back right, zero pad
  input  logic [dpqmm_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                               mismatches,
  output int                               pending
);
  import dpqmm_pkg::*;

  localparam int    NUM_REGS   = int'(REG_INT_LIMIT) + 1;
  localparam int    CMD_W      = 4 * MOT_W;
  localparam longint FULL_CMD  = 25600;
  localparam bit    PITCH_AXIS = 1'b0;
  localparam bit    ROLL_AXIS  = 1'b1;

  logic [GAIN_W-1:0] gain_reg [NUM_REGS];
  longint            err_sum  [2];
  longint            last_err [2];
  logic [CMD_W-1:0]  expected_cmds [$];

  // one axis of the attitude loop: clamped integral, first difference, pid sum
  function automatic longint axis_effort(input bit axis, input longint err);
    longint kp, ki, kd, lim, s, d;
    kp  = (axis == ROLL_AXIS) ? gain_reg[REG_ROLL_KP] : gain_reg[REG_PITCH_KP];
    ki  = (axis == ROLL_AXIS) ? gain_reg[REG_ROLL_KI] : gain_reg[REG_PITCH_KI];
    kd  = (axis == ROLL_AXIS) ? gain_reg[REG_ROLL_KD] : gain_reg[REG_PITCH_KD];
    lim = gain_reg[REG_INT_LIMIT];
    s = err_sum[axis] + err;
    if (s > lim) s = lim;
    else if (s < -lim) s = -lim;
    d = err - last_err[axis];
    err_sum[axis]  = s;
    last_err[axis] = err;
    // each product floored by 8 bits on its own
    return ((kp * err) >>> FRAC_BITS) + ((ki * s) >>> FRAC_BITS) +
           ((kd * d) >>> FRAC_BITS);
  endfunction

  function automatic logic [MOT_W-1:0] to_cmd(input longint v);
    if (v < 0) return '0;
    if (v > FULL_CMD) return MOT_W'(FULL_CMD);
    return MOT_W'(v);
  endfunction

  function automatic logic [CMD_W-1:0] predict_cmds(input logic [IN_DATA_W-1:0] d);
    logic signed [ANG_W-1:0] m_roll, m_pitch, t_roll, t_pitch, thr_raw;
    longint thr, p, r;
    m_roll  = d[0*ANG_W +: ANG_W];
    m_pitch = d[1*ANG_W +: ANG_W];
    t_roll  = d[2*ANG_W +: ANG_W];
    t_pitch = d[3*ANG_W +: ANG_W];
    thr_raw = d[4*ANG_W +: ANG_W];
    thr = thr_raw;
    if (thr < 0) thr = 0;
    else if (thr > FULL_CMD) thr = FULL_CMD;
    p = axis_effort(PITCH_AXIS, longint'(t_pitch) - longint'(m_pitch));
    r = axis_effort(ROLL_AXIS, longint'(t_roll) - longint'(m_roll));
    return {to_cmd(thr - p - r), to_cmd(thr - p + r),
            to_cmd(thr + p - r), to_cmd(thr + p + r)};
  endfunction

  function automatic string motor_name(input int k);
    case (k)
      0: return "front_left";
      1: return "front_right";
      2: return "back_left";
      default: return "back_right";
    endcase
  endfunction

  always @(posedge clk) begin
    logic [CMD_W-1:0] want;
    if (!rst_n) begin
      gain_reg[REG_PITCH_KP]  = 16'd512;
      gain_reg[REG_PITCH_KI]  = 16'd128;
      gain_reg[REG_PITCH_KD]  = 16'd26;
      gain_reg[REG_ROLL_KP]   = 16'd512;
      gain_reg[REG_ROLL_KI]   = 16'd128;
      gain_reg[REG_ROLL_KD]   = 16'd26;
      gain_reg[REG_INT_LIMIT] = 16'd51200;
      err_sum  = '{0, 0};
      last_err = '{0, 0};
      expected_cmds.delete();
      mismatches = 0;
    end else begin
      // out-of-range indexes are dropped
      if (cfg_wr_en && int'(cfg_index) < NUM_REGS)
        gain_reg[cfg_index] = cfg_wdata;
      if (in_tvalid && in_tready)
        expected_cmds.push_back(predict_cmds(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected command transaction, expected none got %h",
                   $time, out_tdata);
        end else begin
          want = expected_cmds.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (out_tdata[k*MOT_W +: MOT_W] !== want[k*MOT_W +: MOT_W]) begin
              mismatches++;
              $display("%0t: %s expected %0d got %0d", $time, motor_name(k),
                       want[k*MOT_W +: MOT_W], out_tdata[k*MOT_W +: MOT_W]);
            end
          end
          if (out_tdata[OUT_DATA_W-1:CMD_W] !== '0) begin
            mismatches++;
            $display("%0t: pad bits expected 0 got %h", $time,
                     out_tdata[OUT_DATA_W-1:CMD_W]);
          end
        end
      end
    end
    pending = expected_cmds.size();
  end

endmodule

// ===== verif/tb_dual_pid_quad_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_dual_pid_quad_motor_mixer - stream testbench for the pid quad mixer
// drives attitude samples in random bursts through several gain and limit
// settings, stalls the motor command stream on its own pattern and leaves the
// prediction and comparison to the checker instantiated beside the block
// ----------------------------------------------------------------------------
module tb_dual_pid_quad_motor_mixer;
  import dpqmm_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 80;
  localparam int NUM_REGS      = int'(REG_INT_LIMIT) + 1;
  // index past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd7;

  localparam logic signed [ANG_W-1:0] ANG_MIN  = 16'sh8000;
  localparam logic signed [ANG_W-1:0] ANG_MAX  = 16'sh7fff;
  localparam logic signed [ANG_W-1:0] THR_FULL = 16'sd25600;
  localparam logic signed [ANG_W-1:0] THR_HALF = 16'sd12800;
  localparam logic signed [ANG_W-1:0] ONE_DEG  = 16'sd256;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [GAIN_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // lsb up: measured roll, measured pitch, target roll, target pitch, throttle
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // lsb up: front left, front right, back left, back right, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int cycle_count = 0;

  // stimulus controls
  bit                long_hold = 1'b0;
  bit                hold_done = 1'b0;
  bit                gaps_on = 1'b1;
  int                burst_left = 1;
  int                roll_bias = 0;
  int                pitch_bias = 0;
  logic [GAIN_W-1:0] reg_plan [NUM_REGS];

  dual_pid_quad_motor_mixer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dpqmm_mixer_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: ready runs of random length broken by short stalls, sometimes
  // none at all, plus one long hold-off when the stimulus asks for it
  initial begin
    int run_len;
    int stall_len;
    wait (rst_n);
    forever begin
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run_len   = $urandom_range(1, 20);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        out_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
        if (stall_len != 0) begin
          out_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  // offer one sample and wait for its transaction; when idling is on the
  // sender drops valid between bursts of random length
  task automatic send_sample(input logic signed [ANG_W-1:0] m_roll, m_pitch,
                             t_roll, t_pitch, throttle);
    in_tvalid <= 1'b1;
    in_tdata  <= {throttle, t_pitch, t_roll, m_pitch, m_roll};
    do begin
      @(posedge clk);
    end while (!in_tready);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // mostly flight-like samples: small angles, target near measured plus a
  // slowly moving bias so the integrals wind up; a quarter are raw noise
  task automatic send_random();
    int m_roll, m_pitch, thr;
    if ($urandom_range(0, 3) == 0) begin
      send_sample(ANG_W'($urandom), ANG_W'($urandom), ANG_W'($urandom),
                  ANG_W'($urandom), ANG_W'($urandom));
    end else begin
      if ($urandom_range(0, 19) == 0) begin
        roll_bias  = int'($urandom_range(0, 8192)) - 4096;
        pitch_bias = int'($urandom_range(0, 8192)) - 4096;
      end
      m_roll  = int'($urandom_range(0, 15360)) - 7680;
      m_pitch = int'($urandom_range(0, 15360)) - 7680;
      thr = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                        : int'($urandom_range(0, 25600));
      send_sample(ANG_W'(m_roll), ANG_W'(m_pitch),
                  ANG_W'(m_roll + roll_bias + int'($urandom_range(0, 512)) - 256),
                  ANG_W'(m_pitch + pitch_bias + int'($urandom_range(0, 512)) - 256),
                  ANG_W'(thr));
    end
  endtask

  task automatic send_random_run(input int count);
    repeat (count) send_random();
  endtask

  // stop offering and wait until every command has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the plan into the block, led by a junk write to the unused index
  task automatic load_regs();
    cfg_wr_en <= 1'b1;
    cfg_index <= UNUSED_IDX;
    cfg_wdata <= GAIN_W'($urandom);
    @(posedge clk);
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_index <= cfg_idx_t'(k);
      cfg_wdata <= reg_plan[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic plan_uniform(input logic [GAIN_W-1:0] gain,
                              input logic [GAIN_W-1:0] limit);
    reg_plan[REG_PITCH_KP]  = gain;
    reg_plan[REG_PITCH_KI]  = gain;
    reg_plan[REG_PITCH_KD]  = gain;
    reg_plan[REG_ROLL_KP]   = gain;
    reg_plan[REG_ROLL_KI]   = gain;
    reg_plan[REG_ROLL_KD]   = gain;
    reg_plan[REG_INT_LIMIT] = limit;
  endtask

  // gains of a usable loop, so the mix is not clamped every time
  task automatic plan_gentle();
    reg_plan[REG_PITCH_KP]  = GAIN_W'($urandom_range(0, 1024));
    reg_plan[REG_PITCH_KI]  = GAIN_W'($urandom_range(0, 256));
    reg_plan[REG_PITCH_KD]  = GAIN_W'($urandom_range(0, 256));
    reg_plan[REG_ROLL_KP]   = GAIN_W'($urandom_range(0, 1024));
    reg_plan[REG_ROLL_KI]   = GAIN_W'($urandom_range(0, 256));
    reg_plan[REG_ROLL_KD]   = GAIN_W'($urandom_range(0, 256));
    reg_plan[REG_INT_LIMIT] = GAIN_W'($urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed samples at the reset gains, back to back
    gaps_on = 1'b0;
    send_sample('0, '0, '0, '0, '0);
    // throttle below zero and above full scale are clamped
    send_sample('0, '0, '0, '0, ANG_MIN);
    send_sample('0, '0, '0, '0, ANG_MAX);
    send_sample('0, '0, '0, '0, THR_FULL);
    // largest negative errors on both axes: integrals wind into the limit, the
    // front left mix goes negative and the back right mix passes full scale
    repeat (3) send_sample(ANG_MAX, ANG_MAX, ANG_MIN, ANG_MIN, THR_HALF);
    // swing to the largest positive errors: big derivative, mixes overflow
    repeat (3) send_sample(ANG_MIN, ANG_MIN, ANG_MAX, ANG_MAX, THR_HALF);
    // axes of opposite sign
    send_sample(ANG_MAX, ANG_MIN, ANG_MIN, ANG_MAX, THR_HALF);
    send_sample('0, '0, ONE_DEG, -ONE_DEG, THR_HALF);
    gaps_on = 1'b1;
    drain_results();

    // zero integral limit holds both sums at zero
    plan_uniform(16'd512, '0);
    load_regs();
    repeat (3) send_sample(ANG_MIN, ANG_MIN, ANG_MAX, ANG_MAX, THR_HALF);
    drain_results();

    // largest gains and limit
    plan_uniform('1, '1);
    load_regs();
    send_sample(ANG_MIN, ANG_MAX, ANG_MAX, ANG_MIN, THR_FULL);
    send_sample(-ONE_DEG, ONE_DEG, '0, '0, THR_HALF);
    send_sample(ANG_MAX, ANG_MIN, ANG_MIN, ANG_MAX, '0);
    drain_results();

    // zero gains pass the clamped throttle straight through
    plan_uniform('0, '1);
    load_regs();
    send_sample(ANG_MIN, ANG_MAX, ANG_MAX, ANG_MIN, THR_HALF);
    send_sample(ANG_MAX, ANG_MIN, ANG_MIN, ANG_MAX, ANG_MIN);
    drain_results();

    // random phase with a usable loop
    plan_gentle();
    load_regs();
    send_random_run(PHASE_ITEMS);
    drain_results();

    // fully random registers; the receiver holds off for a long stretch while
    // samples keep coming back to back until the pipeline backs up
    foreach (reg_plan[k]) reg_plan[k] = GAIN_W'($urandom);
    load_regs();
    long_hold = 1'b1;
    gaps_on = 1'b0;
    send_random_run(20);
    gaps_on = 1'b1;
    send_random_run(PHASE_ITEMS - 20);
    drain_results();

    // usable loop again, with a pause mid-phase until everything is back
    plan_gentle();
    load_regs();
    send_random_run(PHASE_ITEMS / 2);
    drain_results();
    send_random_run(PHASE_ITEMS / 2);
    drain_results();

    // largest gains with a random limit
    plan_uniform('1, GAIN_W'($urandom));
    load_regs();
    send_random_run(PHASE_ITEMS);
    drain_results();

    // no sender gaps at all
    plan_gentle();
    load_regs();
    gaps_on = 1'b0;
    send_random_run(PHASE_ITEMS);
    gaps_on = 1'b1;
    drain_results();

    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dpqmm_pkg.sv
design/dpqmm_cfg_regs.sv
design/dpqmm_err_stage.sv
design/dpqmm_gain_stage.sv
design/dpqmm_mix_stage.sv
design/dual_pid_quad_motor_mixer.sv
design/dpqmm_checker.sv
verif/dpqmm_mixer_checker.sv
verif/tb_dual_pid_quad_motor_mixer.sv
